// ===== rtl/tnac_pkg.sv =====
// Shared types, constants and the neighbor offset table of the tile autotile classifier.
// No dependencies.
package tnac_pkg;

  localparam int unsigned GRID_COLS_DEF = 64;
  localparam int unsigned GRID_ROWS_DEF = 32;

  localparam int unsigned COORD_W  = 10;
  localparam int unsigned STEP_W   = 4;
  localparam int unsigned NUM_NBR  = 12;
  localparam int unsigned NUM_NEAR = 8;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_NBR);

  localparam logic [6:0] COLS_RESET = 7'd64;
  localparam logic [5:0] ROWS_RESET = 6'd32;

  localparam logic [4:0] SHAPE_CORNER_BASE = 5'd16;
  localparam logic [4:0] SHAPE_FULL        = 5'd20;
  localparam logic [3:0] ORTHO_MASK        = 4'b1111;

  typedef enum logic {
    OP_WRITE    = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_e;

  typedef enum logic {
    CFG_COLS = 1'b0,
    CFG_ROWS = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic signed [2:0] dx;
    logic signed [2:0] dy;
  } offset_t;

  typedef struct packed {
    logic oob;
    logic phys_oob;
  } nbr_flags_t;

  typedef struct packed {
    logic              vld;
    logic [STEP_W-1:0] step;
    logic              oob;
  } rd_tag_t;

  // Step 0 is the center, steps 1..12 the neighbors in slot order.
  function automatic offset_t nbr_offset(logic [STEP_W-1:0] step);
    offset_t off;
    off = '{dx: 3'sd0, dy: 3'sd0};
    case (step)
      4'd1:    off = '{dx:  3'sd0, dy: -3'sd1};
      4'd2:    off = '{dx: -3'sd1, dy:  3'sd0};
      4'd3:    off = '{dx:  3'sd1, dy:  3'sd0};
      4'd4:    off = '{dx:  3'sd0, dy:  3'sd1};
      4'd5:    off = '{dx: -3'sd1, dy: -3'sd1};
      4'd6:    off = '{dx:  3'sd1, dy: -3'sd1};
      4'd7:    off = '{dx: -3'sd1, dy:  3'sd1};
      4'd8:    off = '{dx:  3'sd1, dy:  3'sd1};
      4'd9:    off = '{dx:  3'sd0, dy: -3'sd2};
      4'd10:   off = '{dx: -3'sd2, dy:  3'sd0};
      4'd11:   off = '{dx:  3'sd2, dy:  3'sd0};
      4'd12:   off = '{dx:  3'sd0, dy:  3'sd2};
      default: off = '{dx:  3'sd0, dy:  3'sd0};
    endcase
    return off;
  endfunction

endpackage

// ===== rtl/tile_neighbor_autotile_classifier_core.sv =====
// Tile neighbor autotile classifier: visibility map, neighbor scan sequencer, result strobe.
// Depends on tnac_pkg, tnac_map_ram, tnac_nbr_unit and tnac_shape.
//
// After reset the block clears every cell of its map with busy high; configuration
// writes are taken during that time. A write request returns nothing. A classify
// request reads the center cell and its twelve neighbors from the single map read
// port, one per cycle, and presents its result on tile_visible_o and tile_shape_o
// for exactly one cycle with tile_valid_o high, in the result state that follows
// the scan and wait states. The result must be sampled in that cycle; it cannot be
// held off. The next request may be taken in the same cycle as the result.
module tile_neighbor_autotile_classifier_core #(
  parameter int unsigned GRID_COLS = tnac_pkg::GRID_COLS_DEF,
  parameter int unsigned GRID_ROWS = tnac_pkg::GRID_ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       operation_i,
  input  logic [5:0] col_i,
  input  logic [4:0] row_i,
  input  logic       visible_i,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [6:0] cfg_wdata_i,
  output logic       tile_valid_o,
  output logic       tile_visible_o,
  output logic [4:0] tile_shape_o
);
  import tnac_pkg::*;

  localparam int unsigned DEPTH  = GRID_COLS * GRID_ROWS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  clr_addr_q, clr_addr_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [5:0]         col_q, col_d;
  logic [4:0]         row_q, row_d;
  logic [6:0]         cols_q;
  logic [5:0]         rows_q;
  rd_tag_t            tag_q, tag_d;

  logic               accept;
  logic               clr_done;
  logic [5:0]         unit_col;
  logic [4:0]         unit_row;
  logic [STEP_W-1:0]  unit_step;
  logic [ADDR_W-1:0]  unit_addr;
  nbr_flags_t         unit_flags;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic               ram_wdata;
  logic               ram_rdata;

  assign accept   = start && !busy;
  assign clr_done = (clr_addr_q == ADDR_W'(DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      step_q     <= '0;
      tag_q      <= '0;
      cols_q     <= COLS_RESET;
      rows_q     <= ROWS_RESET;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      step_q     <= step_d;
      tag_q      <= tag_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_COLS: cols_q <= cfg_wdata_i;
          CFG_ROWS: rows_q <= cfg_wdata_i[5:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
    row_q <= row_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_done) state_d = ST_IDLE;
      ST_IDLE,
      ST_RESULT: begin
        if (accept && op_e'(operation_i) == OP_CLASSIFY) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN:   if (step_q == LAST_STEP) state_d = ST_WAIT;
      ST_WAIT:   state_d = ST_RESULT;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = !(state_q == ST_IDLE || state_q == ST_RESULT);
    tile_valid_o = (state_q == ST_RESULT);
    clr_addr_d = clr_addr_q;
    step_d     = step_q;
    col_d      = col_q;
    row_d      = row_q;
    tag_d      = '{vld: 1'b0, step: step_q, oob: unit_flags.oob};
    unit_col   = col_q;
    unit_row   = row_q;
    unit_step  = step_q;
    ram_we     = 1'b0;
    ram_waddr  = unit_addr;
    ram_wdata  = visible_i;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = 1'b0;
        clr_addr_d = clr_addr_q + ADDR_W'(1);
      end
      ST_IDLE,
      ST_RESULT: begin
        unit_col  = col_i;
        unit_row  = row_i;
        unit_step = '0;
        col_d     = col_i;
        row_d     = row_i;
        step_d    = '0;
        ram_we    = accept && op_e'(operation_i) == OP_WRITE && !unit_flags.phys_oob;
      end
      ST_SCAN: begin
        tag_d.vld = 1'b1;
        step_d    = step_q + STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

  tnac_map_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (unit_addr),
    .rdata_o (ram_rdata)
  );

  tnac_nbr_unit #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS),
    .ADDR_W    (ADDR_W)
  ) u_nbr_unit (
    .col_i         (unit_col),
    .row_i         (unit_row),
    .step_i        (unit_step),
    .cols_in_use_i (cols_q),
    .rows_in_use_i (rows_q),
    .addr_o        (unit_addr),
    .flags_o       (unit_flags)
  );

  tnac_shape u_shape (
    .clk_i          (clk_i),
    .tag_i          (tag_q),
    .rdata_i        (ram_rdata),
    .tile_visible_o (tile_visible_o),
    .tile_shape_o   (tile_shape_o)
  );

`ifndef SYNTHESIS
  a_classify_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_e'(operation_i) == OP_CLASSIFY) |-> ##15 tile_valid_o)
    else $error("classify result missing after scan");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_e'(operation_i) == OP_WRITE) |=> !tile_valid_o)
    else $error("write request produced a result");

  a_hidden_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tile_valid_o && (!tile_visible_o || tile_shape_o > SHAPE_FULL)) |->
      (!tile_visible_o && tile_shape_o == 5'd0))
    else $error("bad shape on result");

  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_WAIT) |-> !ram_we)
    else $error("map written during scan");
`endif

endmodule

// ===== rtl/tnac_map_ram.sv =====
// Visibility map memory: one write port, one registered read port.
// Depends on nothing.
module tnac_map_ram #(
  parameter int unsigned DEPTH  = 2048,
  parameter int unsigned ADDR_W = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic              wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic              rdata_o
);

  logic mem [DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tnac_nbr_unit.sv =====
// Shared neighbor unit: offset add, grid bound compare and map address.
// Depends on tnac_pkg.
module tnac_nbr_unit #(
  parameter int unsigned GRID_COLS = tnac_pkg::GRID_COLS_DEF,
  parameter int unsigned GRID_ROWS = tnac_pkg::GRID_ROWS_DEF,
  parameter int unsigned ADDR_W    = 11
) (
  input  logic [5:0]                  col_i,
  input  logic [4:0]                  row_i,
  input  logic [tnac_pkg::STEP_W-1:0] step_i,
  input  logic [6:0]                  cols_in_use_i,
  input  logic [5:0]                  rows_in_use_i,
  output logic [ADDR_W-1:0]           addr_o,
  output tnac_pkg::nbr_flags_t        flags_o
);
  import tnac_pkg::*;

  localparam int unsigned COL_W = $clog2(GRID_COLS);
  localparam int unsigned ROW_W = $clog2(GRID_ROWS);
  localparam logic signed [COORD_W-1:0] GC = COORD_W'(GRID_COLS);
  localparam logic signed [COORD_W-1:0] GR = COORD_W'(GRID_ROWS);

  offset_t                    off;
  logic signed [COORD_W-1:0]  x;
  logic signed [COORD_W-1:0]  y;
  logic signed [COORD_W-1:0]  cols_ext;
  logic signed [COORD_W-1:0]  rows_ext;
  logic signed [COORD_W-1:0]  eff_cols;
  logic signed [COORD_W-1:0]  eff_rows;

  always_comb begin
    off      = nbr_offset(step_i);
    x        = $signed({{(COORD_W-6){1'b0}}, col_i}) +
               $signed({{(COORD_W-3){off.dx[2]}}, off.dx});
    y        = $signed({{(COORD_W-5){1'b0}}, row_i}) +
               $signed({{(COORD_W-3){off.dy[2]}}, off.dy});
    cols_ext = $signed({{(COORD_W-7){1'b0}}, cols_in_use_i});
    rows_ext = $signed({{(COORD_W-6){1'b0}}, rows_in_use_i});
    eff_cols = (cols_ext > GC) ? GC : cols_ext;
    eff_rows = (rows_ext > GR) ? GR : rows_ext;

    flags_o.oob      = (x < 0) || (y < 0) || (x >= eff_cols) || (y >= eff_rows);
    flags_o.phys_oob = (x < 0) || (y < 0) || (x >= GC) || (y >= GR);

    if (flags_o.phys_oob) begin
      addr_o = '0;
    end else begin
      addr_o = ADDR_W'(ADDR_W'(y[ROW_W-1:0]) * ADDR_W'(GRID_COLS)) +
               ADDR_W'(x[COL_W-1:0]);
    end
  end

endmodule

// ===== rtl/tnac_shape.sv =====
// Neighbor accumulator and tile shape decode.
// Depends on tnac_pkg.
module tnac_shape (
  input  logic              clk_i,
  input  tnac_pkg::rd_tag_t tag_i,
  input  logic              rdata_i,
  output logic              tile_visible_o,
  output logic [4:0]        tile_shape_o
);
  import tnac_pkg::*;

  logic               center_q;
  logic [NUM_NBR-1:0] mask_q;
  logic [NUM_NEAR-1:0] near;
  logic [3:0]          far;
  logic [4:0]          shape;

  always_ff @(posedge clk_i) begin
    if (tag_i.vld) begin
      if (tag_i.step == '0) begin
        center_q <= !tag_i.oob && rdata_i;
      end else begin
        mask_q[tag_i.step - STEP_W'(1)] <= tag_i.oob || rdata_i;
      end
    end
  end

  always_comb begin
    near  = mask_q[NUM_NEAR-1:0];
    far   = mask_q[NUM_NBR-1:NUM_NEAR];
    shape = {1'b0, mask_q[3:0]};
    if (near[3:0] == ORTHO_MASK && $countones(near[7:4]) == 3) begin
      case (near[7:4])
        4'b1110: shape = SHAPE_CORNER_BASE;
        4'b1101: shape = SHAPE_CORNER_BASE + 5'd1;
        4'b1011: shape = SHAPE_CORNER_BASE + 5'd2;
        4'b0111: shape = SHAPE_CORNER_BASE + 5'd3;
        default: shape = {1'b0, mask_q[3:0]};
      endcase
    end else if (near == {NUM_NEAR{1'b1}} && far == ORTHO_MASK) begin
      shape = SHAPE_FULL;
    end
  end

  assign tile_visible_o = center_q;
  assign tile_shape_o   = center_q ? shape : 5'd0;

endmodule
